/* sv/iswc_pkg.sv */
// ----------------------------------------------------------------------------
// iswc_pkg
// shared types and constants for the insertion sort with counts block
// ----------------------------------------------------------------------------
package iswc_pkg;

  localparam int MAX_ITEMS_DEF = 64;
  localparam int VAL_W         = 32;
  localparam int CMP_W         = 11;
  localparam int MOV_W         = 12;
  localparam int Q_DEPTH       = 2;
  localparam int Q_AW          = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CW          = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic                    last;
    logic                    drop;
  } iswc_item_t;

  typedef enum logic [0:0] {
    ISWC_INSERT,
    ISWC_DRAIN
  } iswc_state_t;

endpackage

/* sv/iswc_front.sv */
// ----------------------------------------------------------------------------
// iswc_front
// accepts input words, tracks list fill and marks words beyond capacity
// ----------------------------------------------------------------------------
module iswc_front #(
  parameter int MAX_ITEMS = iswc_pkg::MAX_ITEMS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               push,
  input  logic signed [iswc_pkg::VAL_W-1:0]  value,
  input  logic                               last_item,
  output logic                               full,
  input  logic                               q_full,
  output logic                               q_push,
  output iswc_pkg::iswc_item_t               q_item
);

  localparam int CNT_W = $clog2(MAX_ITEMS + 1);

  logic [CNT_W-1:0] fill;
  logic             at_cap;

  assign at_cap       = (fill >= CNT_W'(MAX_ITEMS));
  assign full         = q_full;
  assign q_push       = push && !q_full;
  assign q_item.value = value;
  assign q_item.last  = last_item;
  assign q_item.drop  = at_cap;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (q_push) begin
      if (last_item) begin
        fill <= '0;
      end else if (!at_cap) begin
        fill <= fill + CNT_W'(1);
      end
    end
  end

endmodule

/* sv/iswc_queue.sv */
// ----------------------------------------------------------------------------
// iswc_queue
// short register queue between the front and the insertion row
// ----------------------------------------------------------------------------
module iswc_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  iswc_pkg::iswc_item_t item_in,
  output logic                 full,
  input  logic                 pop,
  output logic                 valid,
  output iswc_pkg::iswc_item_t item_out
);

  iswc_pkg::iswc_item_t         slots [iswc_pkg::Q_DEPTH];
  logic [iswc_pkg::Q_AW-1:0]    wr_ptr;
  logic [iswc_pkg::Q_AW-1:0]    rd_ptr;
  logic [iswc_pkg::Q_CW-1:0]    used;
  logic                         do_push;
  logic                         do_pop;

  assign full     = (used == iswc_pkg::Q_CW'(iswc_pkg::Q_DEPTH));
  assign valid    = (used != '0);
  assign item_out = slots[rd_ptr];
  assign do_push  = push && !full;
  assign do_pop   = pop && valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      used   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == iswc_pkg::Q_AW'(iswc_pkg::Q_DEPTH - 1)) ? '0
                                                                     : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == iswc_pkg::Q_AW'(iswc_pkg::Q_DEPTH - 1)) ? '0
                                                                     : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        used <= used + iswc_pkg::Q_CW'(1);
      end else if (do_pop && !do_push) begin
        used <= used - iswc_pkg::Q_CW'(1);
      end
    end
  end

endmodule

/* sv/iswc_row.sv */
// ----------------------------------------------------------------------------
// iswc_row
// sorted insertion row with operation counters, drained through an output
// register once the list is complete
// ----------------------------------------------------------------------------
module iswc_row #(
  parameter int MAX_ITEMS = iswc_pkg::MAX_ITEMS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               q_valid,
  input  iswc_pkg::iswc_item_t               q_item,
  output logic                               q_pop,
  output logic                               empty,
  input  logic                               pop,
  output logic signed [iswc_pkg::VAL_W-1:0]  sorted_value,
  output logic [iswc_pkg::CMP_W-1:0]         comparisons,
  output logic [iswc_pkg::MOV_W-1:0]         moves,
  output logic                               overflow,
  output logic                               last_result
);

  localparam int CNT_W = $clog2(MAX_ITEMS + 1);

  iswc_pkg::iswc_state_t state;
  iswc_pkg::iswc_state_t state_next;

  logic signed [iswc_pkg::VAL_W-1:0] cells [MAX_ITEMS];
  logic signed [iswc_pkg::VAL_W-1:0] cells_ins [MAX_ITEMS];
  logic [MAX_ITEMS-1:0]              le;
  logic [CNT_W-1:0]                  count;
  logic [CNT_W-1:0]                  pos;
  logic [CNT_W-1:0]                  shifts;
  logic [iswc_pkg::CMP_W-1:0]        cmp_total;
  logic [iswc_pkg::MOV_W-1:0]        mov_total;
  logic                              ovf_flag;
  logic                              out_valid;
  logic                              out_free;
  logic                              do_insert;
  logic                              do_drop;
  logic                              do_load;
  logic                              load_fin;

  assign empty    = !out_valid;
  assign out_free = !out_valid || pop;
  assign load_fin = (count == CNT_W'(1));

  // place of the newcomer: after every valid value not greater than it
  always_comb begin
    for (int i = 0; i < MAX_ITEMS; i++) begin
      le[i] = (CNT_W'(i) < count) && !(cells[i] > q_item.value);
    end
    pos = le[MAX_ITEMS-1] ? CNT_W'(MAX_ITEMS) : '0;
    for (int i = 0; i < MAX_ITEMS - 1; i++) begin
      if (le[i] && !le[i+1]) pos = pos | CNT_W'(i + 1);
    end
    shifts = count - pos;
    cells_ins[0] = le[0] ? cells[0] : q_item.value;
    for (int i = 1; i < MAX_ITEMS; i++) begin
      if (le[i]) begin
        cells_ins[i] = cells[i];
      end else if (le[i-1]) begin
        cells_ins[i] = q_item.value;
      end else begin
        cells_ins[i] = cells[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= iswc_pkg::ISWC_INSERT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    do_insert  = 1'b0;
    do_drop    = 1'b0;
    do_load    = 1'b0;
    unique case (state)
      iswc_pkg::ISWC_INSERT: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          do_insert = !q_item.drop;
          do_drop   = q_item.drop;
          if (q_item.last) begin
            state_next = iswc_pkg::ISWC_DRAIN;
          end
        end
      end
      iswc_pkg::ISWC_DRAIN: begin
        if (out_free) begin
          do_load = 1'b1;
          if (load_fin) begin
            state_next = iswc_pkg::ISWC_INSERT;
          end
        end
      end
      default: begin
        state_next = iswc_pkg::ISWC_INSERT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (do_insert) begin
      for (int i = 0; i < MAX_ITEMS; i++) begin
        cells[i] <= cells_ins[i];
      end
    end else if (do_load) begin
      for (int i = 0; i < MAX_ITEMS - 1; i++) begin
        cells[i] <= cells[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      cmp_total <= '0;
      mov_total <= '0;
      ovf_flag  <= 1'b0;
    end else if (do_insert) begin
      count     <= count + CNT_W'(1);
      cmp_total <= cmp_total + iswc_pkg::CMP_W'(shifts);
      mov_total <= mov_total + iswc_pkg::MOV_W'(shifts)
                 + iswc_pkg::MOV_W'(count != '0);
    end else if (do_drop) begin
      ovf_flag <= 1'b1;
    end else if (do_load) begin
      count <= count - CNT_W'(1);
      if (load_fin) begin
        cmp_total <= '0;
        mov_total <= '0;
        ovf_flag  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (do_load) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_load) begin
      sorted_value <= cells[0];
      comparisons  <= load_fin ? cmp_total : '0;
      moves        <= load_fin ? mov_total : '0;
      overflow     <= load_fin ? ovf_flag : 1'b0;
      last_result  <= load_fin;
    end
  end

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_ITEMS))
    else $error("row holds more values than its capacity");

  a_drain_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == iswc_pkg::ISWC_DRAIN |-> count != '0)
    else $error("draining an empty row");

  a_totals_cleared: assert property (@(posedge clk) disable iff (rst)
    do_load && load_fin |=> cmp_total == '0 && mov_total == '0 && !ovf_flag
                            && state == iswc_pkg::ISWC_INSERT)
    else $error("list totals not cleared after final word");

  a_counts_final_only: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_result |-> comparisons == '0 && moves == '0 && !overflow)
    else $error("counts shown on a word that is not final");

endmodule

/* sv/insertion_sort_with_counts.sv */
// ----------------------------------------------------------------------------
// insertion_sort_with_counts
// sorts lists of signed values and reports comparison and move counts
// ----------------------------------------------------------------------------
// Each input word is placed into a sorted register row, all stored values
// being compared with the newcomer at once, so a list is taken in at one
// word per cycle while the row is not draining. When the word marked last
// has been inserted, the row shifts out its n values, one per cycle from the
// output register while the receiver keeps popping, smallest first; the final
// word carries the counts and the overflow flag. Words of the next list wait
// in a two-entry queue during that dump. Words beyond MAX_ITEMS are dropped
// and flagged.
module insertion_sort_with_counts #(
  parameter int MAX_ITEMS = iswc_pkg::MAX_ITEMS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               push,
  output logic                               full,
  input  logic signed [iswc_pkg::VAL_W-1:0]  value,
  input  logic                               last_item,
  output logic                               empty,
  input  logic                               pop,
  output logic signed [iswc_pkg::VAL_W-1:0]  sorted_value,
  output logic [iswc_pkg::CMP_W-1:0]         comparisons,
  output logic [iswc_pkg::MOV_W-1:0]         moves,
  output logic                               overflow,
  output logic                               last_result
);

  logic                 q_full;
  logic                 q_push;
  logic                 q_valid;
  logic                 q_pop;
  iswc_pkg::iswc_item_t q_in;
  iswc_pkg::iswc_item_t q_out;

  iswc_front #(.MAX_ITEMS(MAX_ITEMS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .value     (value),
    .last_item (last_item),
    .full      (full),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (q_in)
  );

  iswc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .item_in  (q_in),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .item_out (q_out)
  );

  iswc_row #(.MAX_ITEMS(MAX_ITEMS)) u_row (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_item       (q_out),
    .q_pop        (q_pop),
    .empty        (empty),
    .pop          (pop),
    .sorted_value (sorted_value),
    .comparisons  (comparisons),
    .moves        (moves),
    .overflow     (overflow),
    .last_result  (last_result)
  );

endmodule

/* test/insertion_sort_with_counts_test.sv */
// ----------------------------------------------------------------------------
// insertion_sort_with_counts_test
// self-checking bench for the insertion sort with counts block
// ----------------------------------------------------------------------------
// Lists of signed words are pushed in bursts with random gaps, and the
// result side is popped with its own stall pattern. A scoreboard keeps a
// sorted row of its own, with comparison and move totals and the overflow
// flag, and works out the full output sequence whenever a word marked last
// is taken. Each popped word is checked field by field against the oldest
// expected word. The directed lists cover single words, the value extremes,
// equal values kept in arrival order, the worst-case descending fill, and
// words dropped once the row is full (including a dropped last word).
// Random lists, mostly short, follow.
// ----------------------------------------------------------------------------
module insertion_sort_with_counts_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VAL_W       = iswc_pkg::VAL_W;
  localparam int CMP_W       = iswc_pkg::CMP_W;
  localparam int MOV_W       = iswc_pkg::MOV_W;
  localparam int ROW_DEPTH   = iswc_pkg::MAX_ITEMS_DEF;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SHOW_LIMIT  = 10;
  localparam int TOTAL_WORDS = 120;

  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};

  typedef enum int {
    SPREAD_WIDE,
    SPREAD_NARROW,
    SPREAD_EDGES
  } value_spread_t;

  typedef enum int {
    STALL_NONE,
    STALL_SHORT,
    STALL_LONG
  } stall_mode_t;

  typedef struct {
    logic signed [VAL_W-1:0] value;
    logic [CMP_W-1:0]        comparisons;
    logic [MOV_W-1:0]        moves;
    logic                    overflow;
    logic                    fin;
  } sorted_word_t;

  class sort_scoreboard;
    logic signed [VAL_W-1:0] row [ROW_DEPTH];
    int unsigned             count;
    logic [CMP_W-1:0]        cmp_total;
    logic [MOV_W-1:0]        mov_total;
    logic                    dropped;
    sorted_word_t            expected_words [$];
    int                      errors;
    int                      checked;

    function new();
      count     = 0;
      cmp_total = '0;
      mov_total = '0;
      dropped   = 1'b0;
      errors    = 0;
      checked   = 0;
    endfunction

    function void note_word(logic signed [VAL_W-1:0] v, logic is_last);
      int pos;
      sorted_word_t w;
      if (count >= ROW_DEPTH) begin
        dropped = 1'b1;
      end else begin
        pos = count;
        while (pos > 0 && row[pos-1] > v) begin
          row[pos] = row[pos-1];
          if (cmp_total != '1) cmp_total++;
          if (mov_total != '1) mov_total++;
          pos--;
        end
        row[pos] = v;
        if (count > 0 && mov_total != '1) mov_total++;
        count++;
      end
      if (is_last) begin
        for (int k = 0; k < count; k++) begin
          w.value       = row[k];
          w.fin         = (k == count - 1);
          w.comparisons = w.fin ? cmp_total : '0;
          w.moves       = w.fin ? mov_total : '0;
          w.overflow    = w.fin ? dropped : 1'b0;
          expected_words.push_back(w);
        end
        count     = 0;
        cmp_total = '0;
        mov_total = '0;
        dropped   = 1'b0;
      end
    endfunction

    function void check_word(sorted_word_t got);
      sorted_word_t exp;
      if (expected_words.size() == 0) begin
        if (errors < SHOW_LIMIT)
          $display("unexpected word: got %0d/%0d/%0d/%0b/%0b",
                   got.value, got.comparisons, got.moves, got.overflow, got.fin);
        errors++;
      end else begin
        exp = expected_words.pop_front();
        if (got.value !== exp.value || got.comparisons !== exp.comparisons ||
            got.moves !== exp.moves || got.overflow !== exp.overflow ||
            got.fin !== exp.fin) begin
          if (errors < SHOW_LIMIT)
            $display("mismatch on word %0d: exp %0d/%0d/%0d/%0b/%0b got %0d/%0d/%0d/%0b/%0b",
                     checked, exp.value, exp.comparisons, exp.moves, exp.overflow, exp.fin,
                     got.value, got.comparisons, got.moves, got.overflow, got.fin);
          errors++;
        end
      end
      checked++;
    endfunction

    function int waiting();
      return expected_words.size();
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    push = 1'b0;
  logic                    full;
  logic signed [VAL_W-1:0] value = '0;
  logic                    last_item = 1'b0;
  logic                    empty;
  logic                    pop = 1'b0;
  logic signed [VAL_W-1:0] sorted_value;
  logic [CMP_W-1:0]        comparisons;
  logic [MOV_W-1:0]        moves;
  logic                    overflow;
  logic                    last_result;

  sort_scoreboard sb = new();
  int cycles = 0;
  int burst_left = 0;
  int words_sent = 0;
  int stall_left = 0;
  stall_mode_t stall_mode = STALL_NONE;

  insertion_sort_with_counts #(
    .MAX_ITEMS(ROW_DEPTH)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .value       (value),
    .last_item   (last_item),
    .empty       (empty),
    .pop         (pop),
    .sorted_value(sorted_value),
    .comparisons (comparisons),
    .moves       (moves),
    .overflow    (overflow),
    .last_result (last_result)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // receiver stall pattern, with a stall mode re-picked at random
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (cycles % 50 == 0) stall_mode = stall_mode_t'($urandom_range(0, 2));
      if (stall_left > 0) begin
        pop <= 1'b0;
        stall_left = stall_left - 1;
      end else begin
        pop <= 1'b1;
        case (stall_mode)
          STALL_SHORT: if ($urandom_range(0, 2) == 0) stall_left = $urandom_range(1, 3);
          STALL_LONG:  if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(4, 15);
          default: stall_left = 0;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    sorted_word_t got;
    if (!rst && pop && !empty) begin
      got.value       = sorted_value;
      got.comparisons = comparisons;
      got.moves       = moves;
      got.overflow    = overflow;
      got.fin         = last_result;
      sb.check_word(got);
    end
  end

  task automatic send_word(input logic signed [VAL_W-1:0] v, input logic is_last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left = burst_left - 1;
    push      <= 1'b1;
    value     <= v;
    last_item <= is_last;
    do @(posedge clk); while (full);
    sb.note_word(v, is_last);
    words_sent++;
  endtask

  function automatic logic signed [VAL_W-1:0] pick_value(value_spread_t spread);
    case (spread)
      SPREAD_NARROW: return $signed($urandom_range(0, 8)) - 4;
      SPREAD_EDGES: begin
        case ($urandom_range(0, 4))
          0: return VAL_MIN;
          1: return VAL_MAX;
          2: return '0;
          3: return -1;
          default: return $urandom();
        endcase
      end
      default: return $urandom();
    endcase
  endfunction

  task automatic send_list(input int len, input value_spread_t spread);
    for (int k = 0; k < len; k++) send_word(pick_value(spread), k == len - 1);
  endtask

  initial begin
    int len;
    value_spread_t spread;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // single-word lists
    send_word('0, 1'b1);
    send_word(VAL_MIN, 1'b1);
    send_word(VAL_MAX, 1'b1);
    // extremes in mixed order
    send_word(VAL_MAX, 1'b0);
    send_word(VAL_MIN, 1'b0);
    send_word(-1, 1'b0);
    send_word(0, 1'b0);
    send_word(1, 1'b1);
    // equal values keep arrival order
    send_word(7, 1'b0);
    send_word(7, 1'b0);
    send_word(-3, 1'b0);
    send_word(7, 1'b0);
    send_word(-3, 1'b1);
    // already ascending
    send_word(-20, 1'b0);
    send_word(-5, 1'b0);
    send_word(5, 1'b0);
    send_word(20, 1'b1);
    // full row in descending order, highest counts, then two words dropped
    // with the last word among them
    for (int k = 0; k < ROW_DEPTH + 2; k++) send_word(VAL_MAX - k, k == ROW_DEPTH + 1);

    while (words_sent < TOTAL_WORDS) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
      spread = value_spread_t'($urandom_range(0, 2));
      send_list(len, spread);
    end
    push <= 1'b0;

    while (sb.waiting() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (sb.errors == 0 && sb.waiting() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
